// File: src/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg: shared types, constants and tables for the isoline generator
// Case-code segment table, edge codes, config and divider interface types.
// ----------------------------------------------------------------------------
package msq_pkg;

   localparam int MAX_COLUMNS   = 1024;
   localparam int COL_BITS      = $clog2(MAX_COLUMNS);
   localparam int WIDTH_BITS    = COL_BITS + 1;
   localparam int SAMPLE_BITS   = 16;
   localparam int DIFF_BITS     = SAMPLE_BITS + 1;
   localparam int FRAC_BITS     = 8;
   localparam int T_BITS        = FRAC_BITS + 1;
   localparam int STEP_BITS     = 16;
   localparam int ORIGIN_BITS   = 32;
   localparam int ROW_BITS      = 16;
   localparam int X_BITS        = 33;
   localparam int Y_BITS        = 34;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_ISO_LEVEL    = 3'd0,
      REG_STEP_X       = 3'd1,
      REG_STEP_Y       = 3'd2,
      REG_ORIGIN_X     = 3'd3,
      REG_ORIGIN_Y     = 3'd4,
      REG_GRID_COLUMNS = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_BOTTOM = 2'd2,
      EDGE_LEFT   = 2'd3
   } edge_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] iso_level;
      logic [STEP_BITS-1:0]          step_x;
      logic [STEP_BITS-1:0]          step_y;
      logic signed [ORIGIN_BITS-1:0] origin_x;
      logic signed [ORIGIN_BITS-1:0] origin_y;
      logic [WIDTH_BITS-1:0]         columns;   // clamped to 2..MAX_COLUMNS
   } cfg_type;

   typedef struct packed {
      logic                        start;
      logic signed [DIFF_BITS-1:0] num;
      logic signed [DIFF_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [T_BITS-1:0] t;
   } div_rsp_type;

   localparam edge_type SEG_EDGES [0:15][0:3] = '{
      '{EDGE_TOP,    EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_TOP,  EDGE_RIGHT},
      '{EDGE_TOP,    EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_LEFT, EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_TOP,    EDGE_TOP,  EDGE_TOP}
   };

   function automatic logic [1:0] seg_count(input logic [3:0] code);
      logic [1:0] n;
      case (code) inside
         4'd0, 4'd15: n = 2'd0;
         4'd5, 4'd10: n = 2'd2;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic edge_type seg_edge(input logic [3:0] code, input logic [1:0] idx);
      return SEG_EDGES[code][idx];
   endfunction

endpackage

// File: src/msq_csr.sv
// ----------------------------------------------------------------------------
// msq_csr: configuration register file
// APB-style write/read of the six control registers; clamps the row width.
// ----------------------------------------------------------------------------
module msq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [msq_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [msq_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [msq_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output msq_pkg::cfg_type                    cfg
);
   import msq_pkg::*;

   logic [SAMPLE_BITS-1:0] iso_ff;
   logic [STEP_BITS-1:0]   step_x_ff;
   logic [STEP_BITS-1:0]   step_y_ff;
   logic [ORIGIN_BITS-1:0] origin_x_ff;
   logic [ORIGIN_BITS-1:0] origin_y_ff;
   logic [WIDTH_BITS-1:0]  columns_ff;
   logic                   wr_en;
   reg_index_type          index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff      <= '0;
         step_x_ff   <= STEP_BITS'(256);
         step_y_ff   <= STEP_BITS'(256);
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         columns_ff  <= WIDTH_BITS'(MAX_COLUMNS);
      end else if (wr_en) begin
         unique case (index)
            REG_ISO_LEVEL:    iso_ff      <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_STEP_X:       step_x_ff   <= csr_pwdata[STEP_BITS-1:0];
            REG_STEP_Y:       step_y_ff   <= csr_pwdata[STEP_BITS-1:0];
            REG_ORIGIN_X:     origin_x_ff <= csr_pwdata[ORIGIN_BITS-1:0];
            REG_ORIGIN_Y:     origin_y_ff <= csr_pwdata[ORIGIN_BITS-1:0];
            REG_GRID_COLUMNS: columns_ff  <= csr_pwdata[WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ISO_LEVEL:    csr_prdata = CSR_DATA_BITS'(iso_ff);
         REG_STEP_X:       csr_prdata = CSR_DATA_BITS'(step_x_ff);
         REG_STEP_Y:       csr_prdata = CSR_DATA_BITS'(step_y_ff);
         REG_ORIGIN_X:     csr_prdata = CSR_DATA_BITS'(origin_x_ff);
         REG_ORIGIN_Y:     csr_prdata = CSR_DATA_BITS'(origin_y_ff);
         REG_GRID_COLUMNS: csr_prdata = CSR_DATA_BITS'(columns_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.iso_level = $signed(iso_ff);
      cfg.step_x    = step_x_ff;
      cfg.step_y    = step_y_ff;
      cfg.origin_x  = $signed(origin_x_ff);
      cfg.origin_y  = $signed(origin_y_ff);
      if (columns_ff < WIDTH_BITS'(2))
         cfg.columns = WIDTH_BITS'(2);
      else if (columns_ff > WIDTH_BITS'(MAX_COLUMNS))
         cfg.columns = WIDTH_BITS'(MAX_COLUMNS);
      else
         cfg.columns = columns_ff;
   end

endmodule

// File: src/msq_line.sv
// ----------------------------------------------------------------------------
// msq_line: previous-row line store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msq_line (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [msq_pkg::COL_BITS-1:0]      rd_addr,
   output logic [msq_pkg::SAMPLE_BITS-1:0]   rd_data,
   input  logic                              wr_en,
   input  logic [msq_pkg::COL_BITS-1:0]      wr_addr,
   input  logic [msq_pkg::SAMPLE_BITS-1:0]   wr_data
);
   import msq_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [MAX_COLUMNS];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/msq_div.sv
// ----------------------------------------------------------------------------
// msq_div: edge fraction divider
// Restoring divider, one quotient bit a cycle, gives clamped Q1.8 fraction.
// ----------------------------------------------------------------------------
module msq_div (
   input  logic                  clock,
   input  logic                  reset,
   input  msq_pkg::div_req_type  div_req,
   output msq_pkg::div_rsp_type  div_rsp
);
   import msq_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [DIFF_BITS-1:0]  rem_ff;
   logic [DIFF_BITS-1:0]  den_ff;
   logic [FRAC_BITS-1:0]  q_ff;
   logic [T_BITS-1:0]     t_ff;
   logic                  num_neg;
   logic                  den_neg;
   logic [DIFF_BITS-1:0]  num_mag;
   logic [DIFF_BITS-1:0]  den_mag;
   logic [DIFF_BITS:0]    shifted;
   logic                  fits;
   logic [DIFF_BITS-1:0]  rem_in;

   always_comb begin
      num_neg = div_req.num[DIFF_BITS-1];
      den_neg = div_req.den[DIFF_BITS-1];
      num_mag = num_neg ? DIFF_BITS'(-div_req.num) : DIFF_BITS'(div_req.num);
      den_mag = den_neg ? DIFF_BITS'(-div_req.den) : DIFF_BITS'(div_req.den);
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? DIFF_BITS'(shifted - {1'b0, den_ff}) : shifted[DIFF_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            if (den_mag == '0) begin
               t_ff    <= T_BITS'(1 << (FRAC_BITS - 1));
               done_ff <= 1'b1;
            end else if (num_mag != '0 && num_neg != den_neg) begin
               t_ff    <= '0;
               done_ff <= 1'b1;
            end else if (num_mag >= den_mag) begin
               t_ff    <= T_BITS'(1 << FRAC_BITS);
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               rem_ff  <= num_mag;
               den_ff  <= den_mag;
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= {q_ff[FRAC_BITS-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               t_ff    <= {1'b0, q_ff[FRAC_BITS-2:0], fits};
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.t    = t_ff;

endmodule

// File: src/marching_squares_segments.sv
// ----------------------------------------------------------------------------
// marching_squares_segments: streaming marching-squares isoline segments
// Flow: a sample that closes no cell or a cell without crossing passes
// through ST_LOAD back to ST_IDLE; each edge point passes ST_START, ST_WAIT
// (where the 8-step divider may run), ST_MUL and ST_POINT; a segment leaves from ST_EMIT.
// Throughput: no new sample is taken until the last is done, paced by the shared fraction divider.
// Reset: counters and corner registers clear; the line store is not cleared.
// ----------------------------------------------------------------------------
module marching_squares_segments (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [msq_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [msq_pkg::X_BITS-1:0]     rsp_start_x,
   output logic signed [msq_pkg::Y_BITS-1:0]     rsp_start_y,
   output logic signed [msq_pkg::X_BITS-1:0]     rsp_end_x,
   output logic signed [msq_pkg::Y_BITS-1:0]     rsp_end_y,
   output logic [msq_pkg::COL_BITS-1:0]          rsp_cell_column,
   output logic [msq_pkg::ROW_BITS-1:0]          rsp_cell_row,
   output logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [msq_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [msq_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [msq_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import msq_pkg::*;

   localparam int PX_BITS  = COL_BITS + STEP_BITS;
   localparam int PY_BITS  = ROW_BITS + STEP_BITS;
   localparam int MUL_BITS = T_BITS + STEP_BITS;
   localparam int OFF_BITS = MUL_BITS - FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_BASE, ST_START, ST_WAIT, ST_MUL, ST_POINT, ST_EMIT
   } state_type;

   cfg_type      cfg;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   state_type                state_ff;
   logic [COL_BITS-1:0]      col_ff;
   logic [ROW_BITS-1:0]      row_ff;
   logic [SAMPLE_BITS-1:0]   left_ff;
   logic [SAMPLE_BITS-1:0]   upleft_ff;
   logic [SAMPLE_BITS-1:0]   s_ff;
   logic [COL_BITS-1:0]      c_ff;
   logic [ROW_BITS-1:0]      r_ff;
   logic [SAMPLE_BITS-1:0]   cv0_ff;
   logic [SAMPLE_BITS-1:0]   cv1_ff;
   logic [SAMPLE_BITS-1:0]   cv3_ff;
   logic [3:0]               code_ff;
   logic                     two_ff;
   logic                     seg_ff;
   logic                     half_ff;
   logic [PX_BITS-1:0]       prodx_ff;
   logic [PY_BITS-1:0]       prody_ff;
   logic [X_BITS-1:0]        bx_ff;
   logic [Y_BITS-1:0]        by_ff;
   logic [OFF_BITS-1:0]      off_ff;
   logic [X_BITS-1:0]        pax_ff;
   logic [Y_BITS-1:0]        pay_ff;
   logic [X_BITS-1:0]        pbx_ff;
   logic [Y_BITS-1:0]        pby_ff;
   logic                     rsp_valid_ff;
   logic [X_BITS-1:0]        rsp_start_x_ff;
   logic [Y_BITS-1:0]        rsp_start_y_ff;
   logic [X_BITS-1:0]        rsp_end_x_ff;
   logic [Y_BITS-1:0]        rsp_end_y_ff;
   logic [COL_BITS-1:0]      rsp_col_ff;
   logic [ROW_BITS-1:0]      rsp_row_ff;
   logic                     rsp_last_ff;

   logic                     accept;
   logic [COL_BITS-1:0]      c_sel;
   logic [ROW_BITS-1:0]      r_sel;
   logic [WIDTH_BITS-1:0]    col_next;
   logic [COL_BITS-1:0]      col_in;
   logic [ROW_BITS-1:0]      row_in;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic [3:0]               code_in;
   logic [1:0]               count_in;
   logic [COL_BITS-1:0]      cm1;
   logic [ROW_BITS-1:0]      rm1;
   edge_type                 edge_cur;
   logic signed [SAMPLE_BITS-1:0] va;
   logic signed [SAMPLE_BITS-1:0] vb;
   logic [STEP_BITS-1:0]     step_sel;
   logic [MUL_BITS-1:0]      off_prod;
   logic [X_BITS-1:0]        px;
   logic [Y_BITS-1:0]        py;
   logic                     out_free;

   msq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msq_line u_line (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_sel),
      .rd_data (rd_data),
      .wr_en   (state_ff == ST_LOAD),
      .wr_addr (c_ff),
      .wr_data (s_ff)
   );

   msq_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // position counters; frame start restarts them before the sample lands
   always_comb begin
      c_sel    = req_frame_start ? '0 : col_ff;
      r_sel    = req_frame_start ? '0 : row_ff;
      col_next = WIDTH_BITS'(c_sel) + 1'b1;
      if (col_next >= cfg.columns) begin
         col_in = '0;
         row_in = r_sel + 1'b1;
      end else begin
         col_in = col_next[COL_BITS-1:0];
         row_in = r_sel;
      end
   end

   always_comb begin
      code_in[0] = $signed(upleft_ff) >= cfg.iso_level;
      code_in[1] = $signed(rd_data)   >= cfg.iso_level;
      code_in[2] = $signed(s_ff)      >= cfg.iso_level;
      code_in[3] = $signed(left_ff)   >= cfg.iso_level;
      count_in   = seg_count(code_in);
      cm1        = c_ff - 1'b1;
      rm1        = r_ff - 1'b1;
      edge_cur   = seg_edge(code_ff, {seg_ff, half_ff});
   end

   always_comb begin
      unique case (edge_cur)
         EDGE_TOP: begin
            va = $signed(cv0_ff);
            vb = $signed(cv1_ff);
         end
         EDGE_RIGHT: begin
            va = $signed(cv1_ff);
            vb = $signed(s_ff);
         end
         EDGE_BOTTOM: begin
            va = $signed(cv3_ff);
            vb = $signed(s_ff);
         end
         default: begin
            va = $signed(cv0_ff);
            vb = $signed(cv3_ff);
         end
      endcase
      div_req.start = (state_ff == ST_START);
      div_req.num   = DIFF_BITS'(cfg.iso_level) - DIFF_BITS'(va);
      div_req.den   = DIFF_BITS'(vb) - DIFF_BITS'(va);
      step_sel      = edge_cur[0] ? cfg.step_y : cfg.step_x;
      off_prod      = MUL_BITS'(div_rsp.t) * MUL_BITS'(step_sel);
   end

   always_comb begin
      unique case (edge_cur)
         EDGE_TOP: begin
            px = bx_ff + X_BITS'(off_ff);
            py = by_ff;
         end
         EDGE_RIGHT: begin
            px = bx_ff + X_BITS'(cfg.step_x);
            py = by_ff + Y_BITS'(off_ff);
         end
         EDGE_BOTTOM: begin
            px = bx_ff + X_BITS'(off_ff);
            py = by_ff + Y_BITS'(cfg.step_y);
         end
         default: begin
            px = bx_ff;
            py = by_ff + Y_BITS'(off_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_EMIT the output register is reloaded whenever it drains
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  s_ff     <= req_sample;
                  c_ff     <= c_sel;
                  r_ff     <= r_sel;
                  col_ff   <= col_in;
                  row_ff   <= row_in;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               cv0_ff    <= upleft_ff;
               cv1_ff    <= rd_data;
               cv3_ff    <= left_ff;
               upleft_ff <= rd_data;
               left_ff   <= s_ff;
               code_ff   <= code_in;
               two_ff    <= (count_in == 2'd2);
               seg_ff    <= 1'b0;
               half_ff   <= 1'b0;
               prodx_ff  <= PX_BITS'(cm1) * PX_BITS'(cfg.step_x);
               prody_ff  <= PY_BITS'(rm1) * PY_BITS'(cfg.step_y);
               if (r_ff != '0 && c_ff != '0 && count_in != 2'd0)
                  state_ff <= ST_BASE;
               else
                  state_ff <= ST_IDLE;
            end
            ST_BASE: begin
               bx_ff    <= X_BITS'(cfg.origin_x) + X_BITS'(prodx_ff);
               by_ff    <= Y_BITS'(cfg.origin_y) + Y_BITS'(prody_ff);
               state_ff <= ST_START;
            end
            ST_START: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (div_rsp.done)
                  state_ff <= ST_MUL;
            end
            ST_MUL: begin
               off_ff   <= off_prod[MUL_BITS-1:FRAC_BITS];
               state_ff <= ST_POINT;
            end
            ST_POINT: begin
               if (!half_ff) begin
                  pax_ff   <= px;
                  pay_ff   <= py;
                  half_ff  <= 1'b1;
                  state_ff <= ST_START;
               end else begin
                  pbx_ff   <= px;
                  pby_ff   <= py;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // hold the segment until the output register is free
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_start_x_ff <= pax_ff;
                  rsp_start_y_ff <= pay_ff;
                  rsp_end_x_ff   <= pbx_ff;
                  rsp_end_y_ff   <= pby_ff;
                  rsp_col_ff     <= cm1;
                  rsp_row_ff     <= rm1;
                  rsp_last_ff    <= ~(two_ff & ~seg_ff);
                  if (two_ff && !seg_ff) begin
                     seg_ff   <= 1'b1;
                     half_ff  <= 1'b0;
                     state_ff <= ST_START;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_x     = $signed(rsp_start_x_ff);
   assign rsp_start_y     = $signed(rsp_start_y_ff);
   assign rsp_end_x       = $signed(rsp_end_x_ff);
   assign rsp_end_y       = $signed(rsp_end_y_ff);
   assign rsp_cell_column = rsp_col_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/msq_check.sv
// ----------------------------------------------------------------------------
// msq_check: port-level checks for the isoline generator
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module msq_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [msq_pkg::X_BITS-1:0]     rsp_start_x,
   input logic signed [msq_pkg::Y_BITS-1:0]     rsp_start_y,
   input logic signed [msq_pkg::X_BITS-1:0]     rsp_end_x,
   input logic signed [msq_pkg::Y_BITS-1:0]     rsp_end_y,
   input logic [msq_pkg::COL_BITS-1:0]          rsp_cell_column,
   input logic [msq_pkg::ROW_BITS-1:0]          rsp_cell_row,
   input logic                                  rsp_last
);

   // a stalled segment holds all of its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_x) &&
      $stable(rsp_start_y) && $stable(rsp_end_x) && $stable(rsp_end_y) &&
      $stable(rsp_cell_column) && $stable(rsp_cell_row) && $stable(rsp_last))
      else $error("segment changed while stalled");

   // one sample at a time: a transfer closes the input
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // the second segment of a cell is still in work while the first leaves
   a_busy_mid_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |-> req_stall)
      else $error("input open before the last segment of a cell");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("segment valid after reset");

endmodule

bind marching_squares_segments msq_check u_msq_check (.*);

// File: verif/marching_squares_segments_test.sv
// ----------------------------------------------------------------------------
// marching_squares_segments_test: self-checking bench for the isoline block
// Streams grid frames through the sample channel and predicts every segment
// in the bench. Each received segment is compared field by field with the
// oldest prediction. Register settings are changed between frames, and only
// while the block is idle. The run covers threshold, step and origin
// extremes, width clamping, stray frame starts and long receiver stalls.
// ----------------------------------------------------------------------------
module marching_squares_segments_test;
   timeunit 1ns;
   timeprecision 1ps;
   import msq_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      logic [X_BITS-1:0]   start_x;
      logic [Y_BITS-1:0]   start_y;
      logic [X_BITS-1:0]   end_x;
      logic [Y_BITS-1:0]   end_y;
      logic [COL_BITS-1:0] cell_column;
      logic [ROW_BITS-1:0] cell_row;
      logic                last;
   } segment_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] smp;
      bit                            first;
      int                            segs;   // -1: predictor only
   } grid_row_type;

   // crossing edges for each corner case, two per segment
   localparam edge_type CROSS_EDGES [16][4] = '{
      '{EDGE_TOP,    EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_TOP,  EDGE_RIGHT},
      '{EDGE_TOP,    EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_LEFT, EDGE_TOP},
      '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_LEFT,   EDGE_TOP,  EDGE_TOP},
      '{EDGE_TOP,    EDGE_TOP,    EDGE_TOP,  EDGE_TOP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [X_BITS-1:0] rsp_start_x, rsp_end_x;
   logic signed [Y_BITS-1:0] rsp_start_y, rsp_end_y;
   logic [COL_BITS-1:0] rsp_cell_column;
   logic [ROW_BITS-1:0] rsp_cell_row;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   marching_squares_segments u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of block state and registers
   logic signed [SAMPLE_BITS-1:0] line_store [MAX_COLUMNS];
   logic signed [SAMPLE_BITS-1:0] left_val, upper_left_val;
   int unsigned col_count, row_count;
   longint iso, step_x, step_y, origin_x, origin_y;
   int unsigned grid_cols;

   segment_type pending_segments [$];
   int errors;
   int samples_sent, segments_seen, settings_used;
   int sender_idle_pct, receiver_idle_pct;
   bit long_hold_req;
   bit long_hold_done;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   function automatic longint edge_fraction(input longint va, input longint vb);
      longint d, t;
      d = vb - va;
      if (d == 0) return 128;
      t = ((iso - va) * 256) / d;
      if (t < 0) t = 0;
      if (t > 256) t = 256;
      return t;
   endfunction

   function automatic void edge_point(input edge_type e, input longint bx, input longint by,
                                      input longint v0, input longint v1, input longint v2,
                                      input longint v3, output longint px, output longint py);
      case (e)
         EDGE_TOP: begin
            px = bx + ((edge_fraction(v0, v1) * step_x) >> 8);
            py = by;
         end
         EDGE_RIGHT: begin
            px = bx + step_x;
            py = by + ((edge_fraction(v1, v2) * step_y) >> 8);
         end
         EDGE_BOTTOM: begin
            px = bx + ((edge_fraction(v3, v2) * step_x) >> 8);
            py = by + step_y;
         end
         default: begin
            px = bx;
            py = by + ((edge_fraction(v0, v3) * step_y) >> 8);
         end
      endcase
   endfunction

   // advance the bench state by one sample and queue its segments
   function automatic int trace_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                       input bit first);
      int unsigned cols, c, r;
      longint v0, v1, v2, v3, bx, by, ax, ay, ex, ey;
      logic [3:0] code;
      int n;
      segment_type seg;
      n = 0;
      cols = (grid_cols < 2) ? 2 : (grid_cols > MAX_COLUMNS) ? MAX_COLUMNS : grid_cols;
      if (first) begin
         col_count = 0;
         row_count = 0;
      end
      c = (col_count >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_count;
      r = row_count;
      if (r >= 1 && c >= 1) begin
         v0 = upper_left_val;
         v1 = line_store[c];
         v2 = smp;
         v3 = left_val;
         code = {v3 >= iso, v2 >= iso, v1 >= iso, v0 >= iso};
         bx = origin_x + longint'(c - 1) * step_x;
         by = origin_y + longint'(r - 1) * step_y;
         n = (code == 4'd0 || code == 4'd15) ? 0 : (code == 4'd5 || code == 4'd10) ? 2 : 1;
         for (int k = 0; k < n; k++) begin
            edge_point(CROSS_EDGES[code][2*k], bx, by, v0, v1, v2, v3, ax, ay);
            edge_point(CROSS_EDGES[code][2*k+1], bx, by, v0, v1, v2, v3, ex, ey);
            seg.start_x = ax[X_BITS-1:0];
            seg.start_y = ay[Y_BITS-1:0];
            seg.end_x = ex[X_BITS-1:0];
            seg.end_y = ey[Y_BITS-1:0];
            seg.cell_column = COL_BITS'(c - 1);
            seg.cell_row = ROW_BITS'(r - 1);
            seg.last = (k == n - 1);
            pending_segments = {pending_segments, seg};
         end
      end
      upper_left_val = line_store[c];
      line_store[c] = smp;
      left_val = smp;
      col_count = c + 1;
      if (col_count >= cols) begin
         col_count = 0;
         row_count = (row_count + 1) & 32'hFFFF;
      end
      return n;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit first,
                              output int n);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_frame_start <= first;
      do @(posedge clock); while (req_stall);
      n = trace_sample(smp, first);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ISO_LEVEL:    iso = longint'($signed(value[15:0]));
         REG_STEP_X:       step_x = value[15:0];
         REG_STEP_Y:       step_y = value[15:0];
         REG_ORIGIN_X:     origin_x = longint'($signed(value));
         REG_ORIGIN_Y:     origin_y = longint'($signed(value));
         default:          grid_cols = value[10:0];
      endcase
   endtask

   task automatic load_settings(input int lvl, input int sx, input int sy, input int ox,
                                input int oy, input int cols);
      wait_idle();
      csr_write(REG_ISO_LEVEL, lvl);
      csr_write(REG_STEP_X, sx);
      csr_write(REG_STEP_Y, sy);
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_GRID_COLUMNS, cols);
      settings_used++;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int v;
      if ($urandom_range(7) == 0) return SAMPLE_BITS'($urandom);
      v = int'(iso) + int'($urandom_range(200)) - 100;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return SAMPLE_BITS'(v);
   endfunction

   // receiver: random stall, plus one long hold on request
   int hold_left = 0;
   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < receiver_idle_pct);
   end

   // check each segment transfer; watchdog on cycles with no transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         segments_seen++;
         if (pending_segments.size() == 0) begin
            report_mismatch("unexpected segment", rsp_cell_row, 0);
         end else begin
            want = pending_segments.pop_front();
            if (rsp_start_x !== want.start_x) report_mismatch("start_x", rsp_start_x, want.start_x);
            if (rsp_start_y !== want.start_y) report_mismatch("start_y", rsp_start_y, want.start_y);
            if (rsp_end_x !== want.end_x) report_mismatch("end_x", rsp_end_x, want.end_x);
            if (rsp_end_y !== want.end_y) report_mismatch("end_y", rsp_end_y, want.end_y);
            if (rsp_cell_column !== want.cell_column)
               report_mismatch("cell_column", rsp_cell_column, want.cell_column);
            if (rsp_cell_row !== want.cell_row)
               report_mismatch("cell_row", rsp_cell_row, want.cell_row);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("** marching_squares_segments: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // extremes, both ambiguous cases, flat regions; width 5, level 0
   grid_row_type grid_table [] = '{
      '{16'sd32767, 1, 0}, '{-16'sd32768, 0, 0}, '{16'sd32767, 0, 0},
      '{-16'sd32768, 0, 0}, '{16'sd0, 0, 0},
      '{-16'sd32768, 0, 0}, '{16'sd32767, 0, 2}, '{-16'sd32768, 0, 2},
      '{16'sd32767, 0, 2}, '{16'sd0, 0, 1},
      '{16'sd0, 0, 0}, '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{-16'sd1, 0, 1},
      '{16'sd1, 0, 0}, '{16'sd1, 0, 0}, '{16'sd1, 0, 0}, '{16'sd1, 0, 0}, '{16'sd1, 0, 1},
      '{16'sd3, 1, -1}, '{16'sd9, 0, -1}
   };

   initial begin
      int n, width, rows, random_done;
      bit paused;
      int lvl_set [8] = '{0, 32767, -32768, 100, -500, 0, 7, -1};
      int sx_set [8] = '{256, 0, 65535, 300, 1, 65535, 256, 40};
      int sy_set [8] = '{256, 65535, 0, 1, 300, 65535, 256, 999};
      int ox_set [8] = '{0, 32'h7FFF_FFFF, 32'h8000_0000, -5, 12345, 32'h8000_0000, 0, 77};
      int oy_set [8] = '{0, 32'h8000_0000, 32'h7FFF_FFFF, 9, -12345, 32'h7FFF_FFFF, 0, -7};
      int col_set [8] = '{4, 3, 6, 0, 1, 12, 2, 9};
      iso = 0; step_x = 256; step_y = 256; origin_x = 0; origin_y = 0; grid_cols = 1024;
      col_count = 0; row_count = 0; left_val = '0; upper_left_val = '0;
      sender_idle_pct = 0; receiver_idle_pct = 0;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_settings(0, 256, 256, 0, 0, 5);
      foreach (grid_table[i]) begin
         send_sample(grid_table[i].smp, grid_table[i].first, n);
         if (grid_table[i].segs >= 0 && n != grid_table[i].segs)
            report_mismatch("segment count", n, grid_table[i].segs);
      end

      // random frames: receiver slow first, then sender slow, then neither
      random_done = 0;
      for (int p = 0; p < 8; p++) begin
         load_settings(lvl_set[p], sx_set[p], sy_set[p], ox_set[p], oy_set[p], col_set[p]);
         width = (col_set[p] < 2) ? 2 : col_set[p];
         while (random_done < (p + 1) * 125) begin
            case (random_done * 3 / 1000)
               0: begin sender_idle_pct = 36; receiver_idle_pct = 77; end
               1: begin sender_idle_pct = 77; receiver_idle_pct = 36; end
               default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            if (p == 2) long_hold_req = 1'b1;
            if (p == 4 && !paused) begin
               paused = 1'b1;
               req_valid <= 1'b0;
               while (pending_segments.size() != 0) @(posedge clock);
            end
            rows = $urandom_range(2, 6);
            for (int k = 0; k < rows * width; k++) begin
               // a stray frame start now and then restarts the grid
               send_sample(random_sample(), k == 0 || $urandom_range(60) == 0, n);
               random_done++;
            end
         end
      end

      wait_idle();
      $display("covered %0d samples, %0d segments, %0d register settings",
               samples_sent, segments_seen, settings_used);
      $display("including level, step and width extremes, stray frame starts, long stalls");
      if (errors == 0 && pending_segments.size() == 0) begin
         $display("** marching_squares_segments: PASSED **");
      end else begin
         $display("%0d mismatches, %0d segments missing", errors, pending_segments.size());
         $display("** marching_squares_segments: FAILED **");
      end
      $finish;
   end

endmodule
